// ===== src/bck_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bck_pkg
// Types and constants shared by the binary Cohen's kappa controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package bck_pkg;

    localparam int LABEL_W   = 2;
    localparam int SCORE_W   = 16;
    localparam int KAPPA_W   = 18;
    localparam int STATUS_W  = 2;
    localparam int FRAC_BITS = 16;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET = 16'sd128;

    // Label codes; any other code counts towards the total only.
    localparam logic [LABEL_W-1:0] LABEL_NEG = 2'd0;
    localparam logic [LABEL_W-1:0] LABEL_POS = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEN_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Saturation limits of the signed Q2.16 result.
    localparam int KAPPA_POS_LIMIT = 131071;
    localparam int KAPPA_NEG_LIMIT = 131072;
    localparam logic signed [KAPPA_W-1:0] KAPPA_MAX = 18'sd131071;
    localparam logic signed [KAPPA_W-1:0] KAPPA_MIN = -18'sd131072;

    // Product selection for the shared multiplier.
    localparam logic [1:0] MUL_AB = 2'd0;   // (tp+fn) * (tp+fp)
    localparam logic [1:0] MUL_CD = 2'd1;   // (tn+fp) * (tn+fn)
    localparam logic [1:0] MUL_AN = 2'd2;   // (tp+tn) * n
    localparam logic [1:0] MUL_NN = 2'd3;   // n * n

    typedef struct packed {
        logic       accept;
        logic       mul_load;
        logic [1:0] mul_sel;
        logic       mul_step;
        logic       mul_store;
        logic       prep;
        logic       div_load;
        logic       div_step;
        logic       res_load;
        logic       clear;
    } cmd_t;

    typedef struct packed {
        logic overflow;
        logic den_zero;
    } stat_t;

endpackage

// ===== src/bck_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bck_ctrl
// Sequencer: accepts samples, then steps the shared multiplier through four
// products, the restoring divider through its quotient bits, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module bck_ctrl #(
    parameter int MAX_ITEMS = 65536
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_last,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  bck_pkg::stat_t stat,
    output bck_pkg::cmd_t  cmd
);
    import bck_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int DW = 2 * CW + FRAC_BITS + 1;
    localparam int SW = $clog2(DW);

    typedef enum logic [6:0] {
        ST_ACCUM = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_STORE = 7'b0001000,
        ST_PREP  = 7'b0010000,
        ST_DLOAD = 7'b0100000,
        ST_DIV   = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [1:0]      prod_reg, prod_next;
    logic            out_valid_reg, out_valid_next;
    logic            done_reg, done_next;
    logic            accept;
    logic            res_load;

    assign in_ready  = (state_reg == ST_ACCUM) && !done_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign res_load  = done_reg && (!out_valid_reg || out_ready);

    // The final hand-over waits in done_reg so that a result still held at
    // the output never blocks the arithmetic from finishing.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        prod_next  = prod_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.accept  = accept;
        cmd.mul_sel = prod_reg;
        cmd.res_load = res_load;
        cmd.clear    = res_load;
        if (res_load)
        begin
            done_next = 1'b0;
        end
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (accept && in_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (stat.overflow)
                begin
                    done_next  = 1'b1;
                    state_next = ST_ACCUM;
                end
                else
                begin
                    cmd.mul_load = 1'b1;
                    step_next    = '0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (step_reg == SW'(CW - 1))
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_STORE:
            begin
                cmd.mul_store = 1'b1;
                if (prod_reg == MUL_NN)
                begin
                    prod_next  = MUL_AB;
                    state_next = ST_PREP;
                end
                else
                begin
                    prod_next  = prod_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DLOAD;
            end
            ST_DLOAD:
            begin
                if (stat.den_zero)
                begin
                    done_next  = 1'b1;
                    state_next = ST_ACCUM;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    step_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == SW'(DW - 1))
                begin
                    done_next  = 1'b1;
                    state_next = ST_ACCUM;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            step_reg      <= '0;
            prod_reg      <= MUL_AB;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

endmodule

// ===== src/bck_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bck_datapath
// Confusion counters, threshold register, shift-add multiplier, restoring
// divider and the rounded, saturated result register.
// ----------------------------------------------------------------------------
module bck_datapath #(
    parameter int MAX_ITEMS = 65536
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   threshold_we,
    input  logic signed [bck_pkg::SCORE_W-1:0]     threshold_wdata,
    input  logic [bck_pkg::LABEL_W-1:0]            label_class,
    input  logic signed [bck_pkg::SCORE_W-1:0]     score,
    input  bck_pkg::cmd_t                          cmd,
    output bck_pkg::stat_t                         stat,
    output logic signed [bck_pkg::KAPPA_W-1:0]     kappa,
    output logic [bck_pkg::STATUS_W-1:0]           status
);
    import bck_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = 2 * CW;
    localparam int DW = PW + FRAC_BITS + 1;
    localparam int RW = PW + 1;

    logic signed [SCORE_W-1:0] threshold_reg;

    logic [CW-1:0] tp_reg, tn_reg, fp_reg, fn_reg, n_reg;
    logic          overflow_reg;
    logic          pred;

    logic [CW:0]   a_w, b_w, c_w, d_w, g_w;
    logic [CW-1:0] op_x, op_y;

    logic [PW-1:0] mcand_reg;
    logic [CW-1:0] mplier_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] s_reg, an_reg, nn_reg;

    logic [PW:0]   num_w;
    logic          neg_reg;
    logic [PW-1:0] mag_reg;
    logic [PW-1:0] den_reg;

    logic [RW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [RW-1:0] trial;
    logic          fits;

    logic signed [KAPPA_W-1:0] kappa_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic signed [KAPPA_W-1:0] kappa_round;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (threshold_we)
        begin
            threshold_reg <= threshold_wdata;
        end
    end

    assign pred = score > threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg       <= '0;
            tn_reg       <= '0;
            fp_reg       <= '0;
            fn_reg       <= '0;
            n_reg        <= '0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            tp_reg       <= '0;
            tn_reg       <= '0;
            fp_reg       <= '0;
            fn_reg       <= '0;
            n_reg        <= '0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (n_reg >= CW'(MAX_ITEMS))
            begin
                overflow_reg <= 1'b1;
            end
            else
            begin
                n_reg <= n_reg + 1'b1;
                if (label_class == LABEL_POS)
                begin
                    if (pred)
                    begin
                        tp_reg <= tp_reg + 1'b1;
                    end
                    else
                    begin
                        fn_reg <= fn_reg + 1'b1;
                    end
                end
                else if (label_class == LABEL_NEG)
                begin
                    if (pred)
                    begin
                        fp_reg <= fp_reg + 1'b1;
                    end
                    else
                    begin
                        tn_reg <= tn_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Marginal sums never exceed the sample count, so they fit the counter width.
    assign a_w = {1'b0, tp_reg} + {1'b0, fn_reg};
    assign b_w = {1'b0, tp_reg} + {1'b0, fp_reg};
    assign c_w = {1'b0, tn_reg} + {1'b0, fp_reg};
    assign d_w = {1'b0, tn_reg} + {1'b0, fn_reg};
    assign g_w = {1'b0, tp_reg} + {1'b0, tn_reg};

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_AB:
            begin
                op_x = a_w[CW-1:0];
                op_y = b_w[CW-1:0];
            end
            MUL_CD:
            begin
                op_x = c_w[CW-1:0];
                op_y = d_w[CW-1:0];
            end
            MUL_AN:
            begin
                op_x = g_w[CW-1:0];
                op_y = n_reg;
            end
            default:
            begin
                op_x = n_reg;
                op_y = n_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            mcand_reg  <= PW'(op_x);
            mplier_reg <= op_y;
            acc_reg    <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_store)
        begin
            unique case (cmd.mul_sel)
                MUL_AB:  s_reg  <= acc_reg;
                MUL_CD:  s_reg  <= s_reg + acc_reg;
                MUL_AN:  an_reg <= acc_reg;
                default: nn_reg <= acc_reg;
            endcase
        end
    end

    assign num_w = {1'b0, an_reg} - {1'b0, s_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            neg_reg <= num_w[PW];
            mag_reg <= num_w[PW] ? PW'(-num_w) : num_w[PW-1:0];
            den_reg <= nn_reg - s_reg;
        end
    end

    // Restoring division of (|num| << 16) + den/2 by den, one quotient bit a cycle.
    assign trial = {rem_reg[RW-2:0], quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            quo_reg <= (DW'(mag_reg) << FRAC_BITS) + DW'(den_reg >> 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg >= DW'(KAPPA_NEG_LIMIT))
            begin
                kappa_round = KAPPA_MIN;
            end
            else
            begin
                kappa_round = -$signed(quo_reg[KAPPA_W-1:0]);
            end
        end
        else
        begin
            if (quo_reg >= DW'(KAPPA_POS_LIMIT))
            begin
                kappa_round = KAPPA_MAX;
            end
            else
            begin
                kappa_round = $signed(quo_reg[KAPPA_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            priority if (overflow_reg)
            begin
                kappa_reg  <= '0;
                status_reg <= STATUS_OVERFLOW;
            end
            else if (stat.den_zero)
            begin
                kappa_reg  <= '0;
                status_reg <= STATUS_DEN_ZERO;
            end
            else
            begin
                kappa_reg  <= kappa_round;
                status_reg <= STATUS_OK;
            end
        end
    end

    assign stat.overflow = overflow_reg;
    assign stat.den_zero = (den_reg == '0);
    assign kappa         = kappa_reg;
    assign status        = status_reg;

endmodule

// ===== src/binary_cohens_kappa.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_cohens_kappa
// Streaming binary Cohen's kappa over thresholded Q8.8 scores, Q2.16 result.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while the block is accumulating and no result
// waits for the output register. A score counts as a positive prediction when
// it is strictly above the threshold. After the sample marked by tlast, a
// shift-add multiplier forms four products and a restoring divider produces one
// quotient bit per cycle; the divider is skipped when the denominator is zero
// and all arithmetic for a set that overflowed. The next sample is taken once
// the result is handed to the output register, even while the result still
// waits at the output. A result carries status 2 with kappa 0 if any sample
// arrived once MAX_ITEMS had been counted, and status 1 with kappa 0 if the
// denominator is zero. All counters clear when the result is handed to the
// output register.
module binary_cohens_kappa #(
    parameter int MAX_ITEMS = 65536
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   threshold_we,
    input  logic signed [bck_pkg::SCORE_W-1:0]     threshold_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [bck_pkg::S_TDATA_W-1:0]          s_axis_tdata,   // label_class, score, zeros
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [bck_pkg::M_TDATA_W-1:0]          m_axis_tdata,   // kappa, zeros
    output logic [bck_pkg::STATUS_W-1:0]           m_axis_tuser    // status
);
    import bck_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic [LABEL_W-1:0]         label_class;
    logic signed [SCORE_W-1:0]  score;
    logic signed [KAPPA_W-1:0]  kappa;
    logic [STATUS_W-1:0]        status;

    assign label_class = s_axis_tdata[LABEL_W-1:0];
    assign score       = $signed(s_axis_tdata[LABEL_W+SCORE_W-1:LABEL_W]);

    bck_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bck_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .threshold_we    (threshold_we),
        .threshold_wdata (threshold_wdata),
        .label_class     (label_class),
        .score           (score),
        .cmd             (cmd),
        .stat            (stat),
        .kappa           (kappa),
        .status          (status)
    );

    assign m_axis_tdata = {{(M_TDATA_W - KAPPA_W){1'b0}}, kappa};
    assign m_axis_tuser = status;

`ifndef SYNTH
    // A closing sample starts the arithmetic, so no sample is taken next cycle.
    a_last_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("sample accepted straight after a closing sample");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_DEN_ZERO
                           || m_axis_tuser == STATUS_OVERFLOW))
        else $error("result carries an undefined status code");

    a_error_kappa_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != STATUS_OK) |-> (kappa == '0))
        else $error("error result with non-zero kappa");

    // A new result is only loaded from the hand-over cycle, when input is held off.
    a_result_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while samples were being accepted");
`endif

endmodule
